// ----- sv/crcfr_pkg.sv -----
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared constants, types and state encodings of the CRC-16 frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package crcfr_pkg;

  // frame buffer geometry
  localparam int FRAME_DEPTH = 64;
  localparam int FRAME_LIMIT = (FRAME_DEPTH < 64) ? FRAME_DEPTH : 64;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);

  // field widths
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 6;
  localparam int CRC_W  = 16;

  // crc-16/modbus, reflected
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
  localparam int CRC_BITS_PER_STEP = 4;
  localparam int CRC_STEPS         = BYTE_W / CRC_BITS_PER_STEP;
  localparam int CRC_REM_W         = $clog2(CRC_STEPS);

  // header bytes
  localparam logic [BYTE_W-1:0] HEAD_FIRST  = 8'h55;
  localparam logic [BYTE_W-1:0] HEAD_SECOND = 8'hAA;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID_HIGH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID_LOW  = 1'd1;

  // result status codes
  localparam logic STATUS_FRAME_BYTE   = 1'b0;
  localparam logic STATUS_CRC_MISMATCH = 1'b1;

  // frame parser position
  typedef enum logic [2:0] {
    PS_HUNT,
    PS_HEAD2,
    PS_LEN,
    PS_IDH,
    PS_IDL,
    PS_DATA,
    PS_CRCH,
    PS_CRCL
  } parse_step_t;

  // result sequencer
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_READ,
    CS_LOAD,
    CS_ERROR
  } ctl_state_t;

  // crc unit command
  typedef struct packed {
    logic init;
    logic start;
  } crc_cmd_t;

  // frame buffer access
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ram_ctl_t;

endpackage

`default_nettype wire

// ----- sv/crcfr_crc_unit.sv -----
// ----------------------------------------------------------------------------
// crcfr_crc_unit
// Running CRC-16/MODBUS register, folded a few bits per cycle over one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfr_crc_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  crcfr_pkg::crc_cmd_t                   cmd,
  input  logic [crcfr_pkg::BYTE_W-1:0]          data,
  output logic [crcfr_pkg::CRC_W-1:0]           crc,
  output logic                                  busy
);
  import crcfr_pkg::*;

  logic [CRC_W-1:0]     crc_r, crc_nxt;
  logic [CRC_REM_W-1:0] rem_r, rem_nxt;
  logic [CRC_W-1:0]     seed;

  // a few shift-xor steps of the reflected polynomial
  function automatic logic [CRC_W-1:0] fold_bits(input logic [CRC_W-1:0] c);
    logic [CRC_W-1:0] v;
    v = c;
    for (int i = 0; i < CRC_BITS_PER_STEP; i++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  // start folds the first bits, the remaining steps follow
  always_comb begin
    seed    = (cmd.init ? CRC_INIT : crc_r) ^ {{(CRC_W-BYTE_W){1'b0}}, data};
    crc_nxt = crc_r;
    rem_nxt = rem_r;
    if (cmd.start) begin
      crc_nxt = fold_bits(seed);
      rem_nxt = CRC_REM_W'(CRC_STEPS - 1);
    end else if (rem_r != '0) begin
      crc_nxt = fold_bits(crc_r);
      rem_nxt = rem_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
      rem_r <= '0;
    end else begin
      crc_r <= crc_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign crc  = crc_r;
  assign busy = (rem_r != '0);

  // a new byte only enters an idle unit
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !busy) else $error("crc start while busy");

  // a byte always keeps the unit busy after the start cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> busy) else $error("crc unit not busy after start");

  // seeding comes with a byte
  a_init_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.init |-> cmd.start) else $error("crc init without start");

endmodule

`default_nettype wire

// ----- sv/crcfr_frame_ram.sv -----
// ----------------------------------------------------------------------------
// crcfr_frame_ram
// Frame buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfr_frame_ram (
  input  logic                         clk,
  input  crcfr_pkg::ram_ctl_t          ctl,
  input  logic [crcfr_pkg::BYTE_W-1:0] wr_data,
  output logic [crcfr_pkg::BYTE_W-1:0] rd_data
);
  import crcfr_pkg::*;

  logic [BYTE_W-1:0] mem [FRAME_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[ctl.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- sv/crc16_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// crc16_frame_receiver
// Hunts 0x55 0xAA framed packets in a byte stream, checks CRC-16/MODBUS over
// the first LEN+1 bytes from the length byte on, and replays those bytes.
// ----------------------------------------------------------------------------
// Input channel: one received byte per item on in_rx_byte, taken when
// in_valid is high and in_stall is low. Header and crc bytes skip the
// crc unit; a byte folded into the crc holds in_stall high while the crc
// unit folds it, four bits a cycle. in_stall is also high while a result
// run is being played out. Result channel: after the crc low byte, a good
// frame gives LEN+1 items (status 0, frame_byte, byte_index, last on the
// final one); a bad crc gives a single item with status 1 and last 1,
// loaded from the CS_ERROR state once the output register is free. Each
// replayed byte is a frame buffer read, then a load into the output register.
// The output register holds its item while out_stall is high and the run
// waits there; input bytes are not taken again until the run has been loaded.
// Configuration: cfg_index 0/1 set the expected device id bytes, always ready.
// The user has the port written only while the block is idle; not enforced.
// Reset (rst_n low, synchronous) returns to hunting, clears the id registers
// and empties the output register; the frame buffer is not cleared, as every
// byte played out is written earlier in the same frame.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_frame_receiver (
  input  logic                            clk,
  input  logic                            rst_n,
  // byte input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [crcfr_pkg::BYTE_W-1:0]    in_rx_byte,
  // results
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_status,
  output logic [crcfr_pkg::BYTE_W-1:0]    out_frame_byte,
  output logic [crcfr_pkg::IDX_W-1:0]     out_byte_index,
  output logic                            out_last,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crcfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crcfr_pkg::BYTE_W-1:0]    cfg_data
);
  import crcfr_pkg::*;

  parse_step_t       parse_r, parse_nxt;
  ctl_state_t        ctl_r, ctl_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [CNT_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [BYTE_W-1:0] crch_r, crch_nxt;
  logic [BYTE_W-1:0] id_high_r, id_low_r;

  logic              out_valid_r, out_valid_nxt;
  logic              out_status_r, out_status_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic [IDX_W-1:0]  out_index_r, out_index_nxt;
  logic              out_last_r, out_last_nxt;

  crc_cmd_t          crc_cmd;
  logic [CRC_W-1:0]  crc_value;
  logic              crc_busy;
  ram_ctl_t          ram_ctl;
  logic [BYTE_W-1:0] rd_data;

  logic              accept_in;
  logic              out_free;
  logic              store_ok;
  logic              fold_ok;
  logic [CNT_W-1:0]  cnt_after;

  // shared crc unit and frame buffer
  crcfr_crc_unit u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (crc_cmd),
    .data  (in_rx_byte),
    .crc   (crc_value),
    .busy  (crc_busy)
  );

  crcfr_frame_ram u_ram (
    .clk     (clk),
    .ctl     (ram_ctl),
    .wr_data (in_rx_byte),
    .rd_data (rd_data)
  );

  // handshakes
  assign in_stall  = (ctl_r != CS_IDLE) || crc_busy;
  assign accept_in = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // buffer position checks
  assign store_ok  = (cnt_r < CNT_W'(FRAME_DEPTH));
  assign fold_ok   = (cnt_r <= len_r);
  assign cnt_after = store_ok ? (cnt_r + 1'b1) : cnt_r;

  // parser and result sequencer
  always_comb begin
    parse_nxt      = parse_r;
    ctl_nxt        = ctl_r;
    cnt_nxt        = cnt_r;
    len_nxt        = len_r;
    rd_ptr_nxt     = rd_ptr_r;
    crch_nxt       = crch_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_byte_nxt   = out_byte_r;
    out_index_nxt  = out_index_r;
    out_last_nxt   = out_last_r;
    crc_cmd        = '0;
    ram_ctl        = '0;
    ram_ctl.wr_addr = cnt_r[ADDR_W-1:0];
    ram_ctl.rd_addr = rd_ptr_r[ADDR_W-1:0];

    case (ctl_r)
      CS_IDLE: begin
        if (accept_in) begin
          case (parse_r)
            PS_HUNT: begin
              if (in_rx_byte == HEAD_FIRST) begin
                parse_nxt = PS_HEAD2;
              end
            end
            PS_HEAD2: begin
              if (in_rx_byte == HEAD_SECOND) begin
                parse_nxt = PS_LEN;
              end else begin
                parse_nxt = PS_HUNT;
                cnt_nxt   = '0;
              end
            end
            PS_LEN: begin
              if ({1'b0, in_rx_byte} >= 9'(FRAME_LIMIT)) begin
                // oversized length drops the frame
                parse_nxt = PS_HUNT;
                cnt_nxt   = '0;
              end else begin
                len_nxt         = CNT_W'(in_rx_byte);
                ram_ctl.wr_en   = 1'b1;
                ram_ctl.wr_addr = '0;
                cnt_nxt         = CNT_W'(1);
                crc_cmd.init    = 1'b1;
                crc_cmd.start   = 1'b1;
                parse_nxt       = PS_IDH;
              end
            end
            PS_IDH, PS_IDL: begin
              if (in_rx_byte == ((parse_r == PS_IDH) ? id_high_r : id_low_r)) begin
                ram_ctl.wr_en = store_ok;
                crc_cmd.start = store_ok && fold_ok;
                cnt_nxt       = cnt_after;
                parse_nxt     = (parse_r == PS_IDH) ? PS_IDL : PS_DATA;
              end else begin
                parse_nxt = PS_HUNT;
                cnt_nxt   = '0;
              end
            end
            PS_DATA: begin
              ram_ctl.wr_en = store_ok;
              crc_cmd.start = store_ok && fold_ok;
              cnt_nxt       = cnt_after;
              if (cnt_after > len_r) begin
                parse_nxt = PS_CRCH;
              end
            end
            PS_CRCH: begin
              crch_nxt  = in_rx_byte;
              parse_nxt = PS_CRCL;
            end
            PS_CRCL: begin
              if ({crch_r, in_rx_byte} == crc_value) begin
                ctl_nxt    = CS_READ;
                rd_ptr_nxt = '0;
              end else begin
                ctl_nxt = CS_ERROR;
              end
              crch_nxt  = '0;
              parse_nxt = PS_HUNT;
              cnt_nxt   = '0;
            end
            default: begin
              parse_nxt = PS_HUNT;
              cnt_nxt   = '0;
            end
          endcase
        end
      end
      // fetch the next buffered byte
      CS_READ: begin
        ram_ctl.rd_en = 1'b1;
        ctl_nxt       = CS_LOAD;
      end
      // hand it to the output register
      CS_LOAD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_FRAME_BYTE;
          out_byte_nxt   = rd_data;
          out_index_nxt  = IDX_W'(rd_ptr_r);
          out_last_nxt   = (rd_ptr_r == len_r);
          if (rd_ptr_r == len_r) begin
            ctl_nxt = CS_IDLE;
          end else begin
            rd_ptr_nxt = rd_ptr_r + 1'b1;
            ctl_nxt    = CS_READ;
          end
        end
      end
      // single crc mismatch item
      CS_ERROR: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_CRC_MISMATCH;
          out_byte_nxt   = '0;
          out_index_nxt  = '0;
          out_last_nxt   = 1'b1;
          ctl_nxt        = CS_IDLE;
        end
      end
      default: begin
        ctl_nxt = CS_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parse_r     <= PS_HUNT;
      ctl_r       <= CS_IDLE;
      cnt_r       <= '0;
      len_r       <= '0;
      rd_ptr_r    <= '0;
      crch_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      parse_r     <= parse_nxt;
      ctl_r       <= ctl_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      crch_r      <= crch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_byte_r   <= out_byte_nxt;
    out_index_r  <= out_index_nxt;
    out_last_r   <= out_last_nxt;
  end

  // device id registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_high_r <= '0;
      id_low_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEVICE_ID_HIGH: id_high_r <= cfg_data;
        REG_DEVICE_ID_LOW:  id_low_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_frame_byte = out_byte_r;
  assign out_byte_index = out_index_r;
  assign out_last       = out_last_r;

  // playback never runs past the frame
  a_ptr_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r == CS_LOAD) |-> (rd_ptr_r <= len_r)) else $error("read pointer past frame");

  // a read is always followed by its load
  a_read_load: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r == CS_READ) |=> (ctl_r == CS_LOAD)) else $error("read not followed by load");

  // the buffer count is clear before a frame begins
  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (parse_r == PS_HUNT || parse_r == PS_HEAD2 || parse_r == PS_LEN) |-> (cnt_r == '0))
    else $error("byte count not clear while hunting");

  // buffer count stays inside the frame limit
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FRAME_LIMIT)) else $error("byte count beyond frame limit");

endmodule

`default_nettype wire

// ----- verif/crc16_frame_receiver_tb.sv -----
// ----------------------------------------------------------------------------
// crc16_frame_receiver testbench
// Feeds byte streams of framed packets, noise and broken frames to the
// receiver, predicts the replayed bytes and crc error items in a scoreboard
// and compares each result item field by field. The input idles and the
// output stalls at random, and the device id is changed between phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import crcfr_pkg::*;

  localparam int RANDOM_BYTES_PER_PHASE = 50;
  localparam int NUM_PHASES             = 5;
  localparam int DRAIN_CYCLES           = 16;
  localparam int MAX_REPORTS            = 60;
  localparam int TIMEOUT_NS             = 2_000_000;

  // how the crc bytes of a generated frame are formed
  typedef enum int {
    CRC_GOOD,
    CRC_CORRUPT,
    CRC_HIGH_ZERO
  } crc_mode_t;

  typedef struct packed {
    logic              status;
    logic [BYTE_W-1:0] frame_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              last;
  } frame_result_t;

  // frame parser model and store of expected result items
  class frame_scoreboard;
    logic [BYTE_W-1:0] id_high;
    logic [BYTE_W-1:0] id_low;
    parse_step_t       step;
    logic [BYTE_W-1:0] frame_len;
    int unsigned       byte_cnt;
    logic [BYTE_W-1:0] buffered [FRAME_DEPTH];
    logic [BYTE_W-1:0] crc_high_rx;
    logic [CRC_W-1:0]  crc_acc;
    frame_result_t     expected_q [$];
    int                errors;

    function new();
      id_high     = '0;
      id_low      = '0;
      step        = PS_HUNT;
      frame_len   = '0;
      byte_cnt    = 0;
      crc_high_rx = '0;
      crc_acc     = CRC_INIT;
      errors      = 0;
    endfunction

    static function logic [CRC_W-1:0] crc_fold(logic [CRC_W-1:0] crc,
                                               logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < BYTE_W; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
    endfunction

    function void set_id(logic [CFG_IDX_W-1:0] index, logic [BYTE_W-1:0] value);
      case (index)
        REG_DEVICE_ID_HIGH: id_high = value;
        REG_DEVICE_ID_LOW:  id_low  = value;
        default: ;
      endcase
    endfunction

    function void restart_hunt();
      step     = PS_HUNT;
      byte_cnt = 0;
    endfunction

    // buffer one byte, fold it into the crc while within LEN+1
    function void buffer_byte(logic [BYTE_W-1:0] b);
      if (byte_cnt < FRAME_DEPTH) begin
        buffered[byte_cnt] = b;
        if (byte_cnt < int'(frame_len) + 1) crc_acc = crc_fold(crc_acc, b);
        byte_cnt = (byte_cnt + 1) & 32'h7F;
      end
    endfunction

    // one accepted input byte
    function void note_byte(logic [BYTE_W-1:0] b);
      frame_result_t r;
      case (step)
        PS_HUNT: begin
          if (b == HEAD_FIRST) step = PS_HEAD2;
        end
        PS_HEAD2: begin
          if (b == HEAD_SECOND) step = PS_LEN;
          else restart_hunt();
        end
        PS_LEN: begin
          if (int'(b) + 1 > FRAME_LIMIT) begin
            restart_hunt();
          end else begin
            frame_len = b;
            byte_cnt  = 0;
            crc_acc   = CRC_INIT;
            buffer_byte(b);
            step = PS_IDH;
          end
        end
        PS_IDH: begin
          if (b == id_high) begin
            buffer_byte(b);
            step = PS_IDL;
          end else begin
            restart_hunt();
          end
        end
        PS_IDL: begin
          if (b == id_low) begin
            buffer_byte(b);
            step = PS_DATA;
          end else begin
            restart_hunt();
          end
        end
        PS_DATA: begin
          buffer_byte(b);
          if (byte_cnt >= int'(frame_len) + 1) step = PS_CRCH;
        end
        PS_CRCH: begin
          crc_high_rx = b;
          step = PS_CRCL;
        end
        default: begin
          if ({crc_high_rx, b} == crc_acc) begin
            // good frame: replay the buffered bytes
            for (int k = 0; k <= int'(frame_len) && k < FRAME_LIMIT; k++) begin
              r.status     = STATUS_FRAME_BYTE;
              r.frame_byte = buffered[k];
              r.byte_index = IDX_W'(k);
              r.last       = (k == int'(frame_len));
              expected_q.push_back(r);
            end
          end else begin
            r.status     = STATUS_CRC_MISMATCH;
            r.frame_byte = '0;
            r.byte_index = '0;
            r.last       = 1'b1;
            expected_q.push_back(r);
          end
          crc_high_rx = '0;
          crc_acc     = CRC_INIT;
          restart_hunt();
        end
      endcase
    endfunction

    function void report(string field, int want, int got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s expected %0h got %0h", $time, field, want, got);
    endfunction

    // one accepted result item against the oldest expectation
    function void check_result(frame_result_t got);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: expected no item got status %0h byte %0h index %0h last %0h",
                   $time, got.status, got.frame_byte, got.byte_index, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.frame_byte !== want.frame_byte)
        report("frame_byte", want.frame_byte, got.frame_byte);
      if (got.byte_index !== want.byte_index)
        report("byte_index", want.byte_index, got.byte_index);
      if (got.last !== want.last) report("last", want.last, got.last);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic                 out_status;
  logic [BYTE_W-1:0]    out_frame_byte;
  logic [IDX_W-1:0]     out_byte_index;
  logic                 out_last;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [BYTE_W-1:0]    cfg_data   = '0;

  frame_scoreboard sb = new();
  int              bytes_counted = 0;
  int              frames_sent   = 0;
  bit              in_no_gaps    = 1'b0;
  bit              out_no_gaps   = 1'b0;
  int              stall_left    = 0;

  crc16_frame_receiver dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_frame_byte (out_frame_byte),
    .out_byte_index (out_byte_index),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: check accepted items, then stall for a random wait
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_result('{out_status, out_frame_byte, out_byte_index, out_last});
        if ($urandom_range(0, 31) == 0) out_no_gaps = ~out_no_gaps;
        stall_left = out_no_gaps ? 0 : $urandom_range(0, 9);
        out_stall <= (stall_left != 0);
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= (stall_left != 0);
      end
    end
  end

  // send one item; valid stays high when the next item follows with no gap
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if ($urandom_range(0, 31) == 0) in_no_gaps = ~in_no_gaps;
    gap = in_no_gaps ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // bytes dropped while hunting do not count
    if (sb.step != PS_HUNT || b == HEAD_FIRST) bytes_counted++;
    sb.note_byte(b);
  endtask

  // write both device id registers
  task automatic write_device_id(input logic [BYTE_W-1:0] hi, input logic [BYTE_W-1:0] lo);
    logic [CFG_IDX_W-1:0] idx;
    for (int r = 0; r < 2; r++) begin
      idx = (r == 0) ? REG_DEVICE_ID_HIGH : REG_DEVICE_ID_LOW;
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= (r == 0) ? hi : lo;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_id(idx, (r == 0) ? hi : lo);
    end
    cfg_valid <= 1'b0;
  endtask

  // fill with zero bytes until the parser is back to hunting
  task automatic sync_to_hunt();
    while (sb.step != PS_HUNT) send_byte(8'h00);
  endtask

  // header, LEN, id, data and crc of one frame
  task automatic send_frame(input int len, input bit wrong_id, input crc_mode_t mode);
    logic [BYTE_W-1:0] body [$];
    logic [CRC_W-1:0]  crc;
    int                n_data;
    body.push_back(8'(len));
    body.push_back(sb.id_high);
    body.push_back(sb.id_low);
    if (wrong_id) body[$urandom_range(1, 2)] ^= 8'($urandom_range(1, 255));
    n_data = (len >= 3) ? len - 2 : 1;
    repeat (n_data) begin
      if ($urandom_range(0, 7) == 0)
        body.push_back($urandom_range(0, 1) ? HEAD_FIRST : HEAD_SECOND);
      else
        body.push_back(8'($urandom_range(0, 255)));
    end
    crc = CRC_INIT;
    for (int i = 0; i <= len; i++) crc = frame_scoreboard::crc_fold(crc, body[i]);
    case (mode)
      CRC_CORRUPT:   crc ^= 16'($urandom_range(1, 65535));
      CRC_HIGH_ZERO: crc = {8'h00, crc[7:0] ^ ((crc[15:8] == 8'h00) ? 8'h01 : 8'h00)};
      default: ;
    endcase
    send_byte(HEAD_FIRST);
    send_byte(HEAD_SECOND);
    foreach (body[i]) send_byte(body[i]);
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
  endtask

  // stimulus
  initial begin
    logic [BYTE_W-1:0] id_hi;
    logic [BYTE_W-1:0] id_lo;
    logic [BYTE_W-1:0] opening [15];
    int                target;
    int                choice;
    int                len;
    int                pick;
    crc_mode_t         mode;

    // header mismatch with a second 0x55, oversized LEN, id high and id low mismatch
    opening = '{HEAD_FIRST, HEAD_FIRST, HEAD_SECOND,
                HEAD_FIRST, HEAD_SECOND, 8'(FRAME_LIMIT),
                HEAD_FIRST, HEAD_SECOND, 8'h00, 8'h01,
                HEAD_FIRST, HEAD_SECOND, 8'h00, 8'h00, 8'hFF};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       begin id_hi = 8'h00; id_lo = 8'h00; end
        1:       begin id_hi = 8'hFF; id_lo = 8'hFF; end
        2:       begin id_hi = HEAD_FIRST; id_lo = HEAD_SECOND; end
        3:       begin id_hi = 8'hFF; id_lo = 8'h00; end
        default: begin id_hi = 8'($urandom_range(0, 255)); id_lo = 8'($urandom_range(0, 255)); end
      endcase
      write_device_id(id_hi, id_lo);

      if (ph == 0) begin
        foreach (opening[i]) send_byte(opening[i]);
        // short LEN, then a bad crc with a zero high byte
        send_frame(0, 1'b0, CRC_GOOD);
        send_frame(1, 1'b0, CRC_HIGH_ZERO);
      end

      target = bytes_counted + RANDOM_BYTES_PER_PHASE;
      while (bytes_counted < target) begin
        choice = $urandom_range(0, 99);
        if (choice < 75) begin
          // well-formed frame, mostly short, now and then long or broken
          sync_to_hunt();
          pick = $urandom_range(0, 7);
          if (frames_sent == 2) len = FRAME_LIMIT - 1;
          else if (pick == 0) len = $urandom_range(0, FRAME_LIMIT - 1);
          else len = $urandom_range(0, 9);
          pick = $urandom_range(0, 19);
          mode = (pick < 15) ? CRC_GOOD : (pick < 19) ? CRC_CORRUPT : CRC_HIGH_ZERO;
          send_frame(len, $urandom_range(0, 24) == 0, mode);
          frames_sent++;
        end else if (choice < 87) begin
          // line noise
          repeat ($urandom_range(1, 6)) begin
            pick = $urandom_range(0, 7);
            send_byte(pick == 0 ? HEAD_FIRST : pick == 1 ? HEAD_SECOND :
                      8'($urandom_range(0, 255)));
          end
        end else if (choice < 93) begin
          // oversized LEN
          send_byte(HEAD_FIRST);
          send_byte(HEAD_SECOND);
          send_byte(8'($urandom_range(FRAME_LIMIT, 255)));
        end else begin
          // truncated frame
          send_byte(HEAD_FIRST);
          send_byte(HEAD_SECOND);
          send_byte(8'($urandom_range(0, 9)));
          repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)));
        end
      end

      // leave the parser hunting and let the block go idle
      sync_to_hunt();
      in_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
